[src/scplk_pkg.sv]
// scplk_pkg: shared widths, codes and divider structs of the step cycle phase lookup
// no dependencies; used by every module of the block but scplk_ram
`timescale 1ns / 1ps

package scplk_pkg;

    // field widths
    localparam int READING_W = 14;
    localparam int INDEX_W   = 6;
    localparam int ENTRY_W   = 16;
    localparam int PHASE_W   = 8;
    localparam int COUNT_W   = 7;
    localparam int CPC_W     = 15;
    localparam int PROD_W    = 32;

    // configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 15;

    // default table depth
    localparam int DEF_MAX_STEP_CYCLES = 64;

    // reset value of counts per cycle
    localparam logic [CPC_W-1:0] CPC_RESET = 15'd327;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_STEP_CYCLE_COUNT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_COUNTS_PER_CYCLE = 1'b1;

    // request action codes
    localparam logic ACTION_LOOKUP = 1'b0;
    localparam logic ACTION_WRITE  = 1'b1;

    // divider start request
    typedef struct packed {
        logic              start;
        logic [PROD_W-1:0] dividend;
        logic [CPC_W-1:0]  divisor;
    } div_req_t;

    // divider response
    typedef struct packed {
        logic               done;
        logic [PHASE_W-1:0] quotient;
    } div_rsp_t;

endpackage

[src/scplk_if.sv]
// scplk_in_if / scplk_out_if: valid-ready channels of the step cycle phase lookup
// depends on scplk_pkg for field widths
`timescale 1ns / 1ps

interface scplk_in_if;
    logic                            valid;
    logic                            ready;
    logic                            action;
    logic [scplk_pkg::READING_W-1:0] reading;
    logic [scplk_pkg::INDEX_W-1:0]   entry_index;
    logic [scplk_pkg::ENTRY_W-1:0]   entry_value;

    modport source (output valid, action, reading, entry_index, entry_value, input ready);
    modport sink   (input valid, action, reading, entry_index, entry_value, output ready);
endinterface

interface scplk_out_if;
    logic                          valid;
    logic                          ready;
    logic [scplk_pkg::PHASE_W-1:0] phase;
    logic                          uncalibrated;

    modport source (output valid, phase, uncalibrated, input ready);
    modport sink   (input valid, phase, uncalibrated, output ready);
endinterface

[src/scplk_ram.sv]
// scplk_ram: generic single write port, single read port RAM with registered read
// no dependencies
`timescale 1ns / 1ps

module scplk_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[src/scplk_div.sv]
// scplk_div: restoring divider, one quotient bit per cycle, 32-bit dividend
// depends on scplk_pkg for the request and response structs
`timescale 1ns / 1ps

module scplk_div (
    input  logic                clk,
    input  logic                rst_n,
    input  scplk_pkg::div_req_t req,
    output scplk_pkg::div_rsp_t rsp
);
    import scplk_pkg::*;

    localparam int CNT_W = $clog2(PROD_W);

    logic [CPC_W-1:0]  rem_reg, rem_next;
    logic [PROD_W-1:0] quo_reg, quo_next;
    logic [CPC_W-1:0]  dvs_reg, dvs_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;

    logic [CPC_W:0]    shifted;
    logic              ge;

    // one restoring step: shift in the next dividend bit, subtract if it fits
    assign shifted = {rem_reg, quo_reg[PROD_W-1]};
    assign ge      = shifted >= {1'b0, dvs_reg};

    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            rem_next  = '0;
            quo_next  = req.dividend;
            dvs_next  = req.divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? CPC_W'(shifted - {1'b0, dvs_reg}) : shifted[CPC_W-1:0];
            quo_next = {quo_reg[PROD_W-2:0], ge};
            cnt_next = cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_W'(PROD_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg[PHASE_W-1:0];

endmodule

[src/step_cycle_phase_lookup_top.sv]
// step_cycle_phase_lookup_top: sequencer, table scan and output register
// depends on scplk_pkg, scplk_if, scplk_ram and scplk_div
`timescale 1ns / 1ps

// Maps an absolute encoder reading to a phase inside the current step cycle.
// in_ch carries requests: a write request stores entry_value at entry_index of
// the cycle start table; a lookup request returns the phase of reading.
// out_ch carries one result per request (phase, uncalibrated).
// Configuration: cfg_we writes cfg_data to register cfg_index at the clock edge
// (0: step cycle count, 1: counts per cycle); write only while idle.
// Results: a write request, or a lookup while the step cycle count is zero,
// gives its result in the cycle after it is taken. A lookup scans at most
// min(count, MAX_STEP_CYCLES) - 1 table entries (63 with 64 entries), one
// RAM read per scanned entry, then runs the 32-step serial divider. One
// request is in work at a time: in_ch.ready is high only while the sequencer
// is idle and the output register is free.
// Stall: a result waits in the output register while out_ch.ready is low and
// holds the block. Reset clears the sequencer, the output register and the
// registers (count 0, counts per cycle 327); the table is undefined until written.

module step_cycle_phase_lookup_top #(
    parameter int MAX_STEP_CYCLES = scplk_pkg::DEF_MAX_STEP_CYCLES
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [scplk_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [scplk_pkg::CFG_DATA_W-1:0] cfg_data,
    scplk_in_if.sink                         in_ch,
    scplk_out_if.source                      out_ch
);
    import scplk_pkg::*;

    localparam int IDX_W = (MAX_STEP_CYCLES > 1) ? $clog2(MAX_STEP_CYCLES) : 1;
    localparam int NW    = $clog2(MAX_STEP_CYCLES + 1);
    localparam int R_W   = READING_W + 1;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_FIRST = 7'b0000010,
        S_SCAN  = 7'b0000100,
        S_DIFF  = 7'b0001000,
        S_MUL   = 7'b0010000,
        S_DIV   = 7'b0100000,
        S_DONE  = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    logic [COUNT_W-1:0]   count_reg, count_next;
    logic [CPC_W-1:0]     cpc_reg, cpc_next;
    logic [READING_W-1:0] reading_reg, reading_next;
    logic [R_W-1:0]       r_reg, r_next;
    logic [ENTRY_W-1:0]   prev_reg, prev_next;
    logic [ENTRY_W-1:0]   sel_reg, sel_next;
    logic [PROD_W-1:0]    diff_reg, diff_next;
    logic [NW-1:0]        n_reg, n_next;
    logic [NW-1:0]        idx_reg, idx_next;
    logic                 out_valid_reg, out_valid_next;
    logic [PHASE_W-1:0]   phase_reg, phase_next;
    logic                 uncal_reg, uncal_next;

    logic                 slot_free;
    logic                 accept;
    logic                 ram_we;
    logic [IDX_W-1:0]     ram_waddr;
    logic [IDX_W-1:0]     ram_raddr;
    logic [ENTRY_W-1:0]   ram_rdata;
    logic                 in_range;
    logic [NW-1:0]        idx_inc;
    div_req_t             div_req;
    div_rsp_t             div_rsp;

    // handshake
    assign slot_free   = !out_valid_reg || out_ch.ready;
    assign in_ch.ready = (state_reg == S_IDLE) && slot_free;
    assign accept      = in_ch.valid && in_ch.ready;

    // table writes, out-of-range indexes are dropped
    assign ram_we    = accept && (in_ch.action == ACTION_WRITE)
                       && (32'(in_ch.entry_index) < 32'(MAX_STEP_CYCLES));
    assign ram_waddr = IDX_W'(in_ch.entry_index);

    assign idx_inc = idx_reg + NW'(1);

    // read address: entry 0 while idle, then the entry after the current one
    always_comb
    begin
        case (state_reg)
            S_IDLE:  ram_raddr = '0;
            S_FIRST: ram_raddr = IDX_W'(1);
            S_SCAN:  ram_raddr = idx_inc[IDX_W-1:0];
            default: ram_raddr = '0;
        endcase
    end

    scplk_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_STEP_CYCLES)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (in_ch.entry_value),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // reading falls in [previous start, current start)
    assign in_range = ({1'b0, r_reg} >= prev_reg) && ({1'b0, r_reg} < ram_rdata);

    // phase scaling: (diff * 255) mod 2^32, then divide by counts per cycle
    assign div_req.start    = (state_reg == S_MUL);
    assign div_req.dividend = (diff_reg << 8) - diff_reg;
    assign div_req.divisor  = cpc_reg;

    scplk_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        cpc_next       = cpc_reg;
        reading_next   = reading_reg;
        r_next         = r_reg;
        prev_next      = prev_reg;
        sel_next       = sel_reg;
        diff_next      = diff_reg;
        n_next         = n_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        phase_next     = phase_reg;
        uncal_next     = uncal_reg;

        if (out_valid_reg && out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end

        // configuration writes
        if (cfg_we)
        begin
            case (cfg_index)
                REG_STEP_CYCLE_COUNT: count_next = cfg_data[COUNT_W-1:0];
                REG_COUNTS_PER_CYCLE: cpc_next   = cfg_data;
                default: ;
            endcase
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (in_ch.action == ACTION_WRITE)
                    begin
                        out_valid_next = 1'b1;
                        phase_next     = '0;
                        uncal_next     = 1'b0;
                    end
                    else if (count_reg == '0)
                    begin
                        out_valid_next = 1'b1;
                        phase_next     = '0;
                        uncal_next     = 1'b1;
                    end
                    else
                    begin
                        reading_next = in_ch.reading;
                        if (32'(count_reg) > 32'(MAX_STEP_CYCLES))
                        begin
                            n_next = NW'(MAX_STEP_CYCLES);
                        end
                        else
                        begin
                            n_next = NW'(count_reg);
                        end
                        state_next = S_FIRST;
                    end
                end
            end
            S_FIRST:
            begin
                // wrap a reading below the first start by one turn
                r_next    = {({2'b00, reading_reg} < ram_rdata), reading_reg};
                prev_next = ram_rdata;
                idx_next  = NW'(1);
                if (n_reg == NW'(1))
                begin
                    sel_next   = ram_rdata;
                    state_next = S_DIFF;
                end
                else
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (in_range)
                begin
                    sel_next   = prev_reg;
                    state_next = S_DIFF;
                end
                else if (idx_inc >= n_reg)
                begin
                    sel_next   = ram_rdata;
                    state_next = S_DIFF;
                end
                else
                begin
                    prev_next = ram_rdata;
                    idx_next  = idx_inc;
                end
            end
            S_DIFF:
            begin
                diff_next  = PROD_W'(r_reg) - PROD_W'(sel_reg);
                state_next = S_MUL;
            end
            S_MUL:
            begin
                state_next = S_DIV;
            end
            S_DIV:
            begin
                if (div_rsp.done)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    phase_next     = div_rsp.quotient;
                    uncal_next     = 1'b0;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state and registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            cpc_reg       <= CPC_RESET;
            n_reg         <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            cpc_reg       <= cpc_next;
            n_reg         <= n_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        reading_reg <= reading_next;
        r_reg       <= r_next;
        prev_reg    <= prev_next;
        sel_reg     <= sel_next;
        diff_reg    <= diff_next;
        phase_reg   <= phase_next;
        uncal_reg   <= uncal_next;
    end

    assign out_ch.valid        = out_valid_reg;
    assign out_ch.phase        = phase_reg;
    assign out_ch.uncalibrated = uncal_reg;

endmodule

[src/scplk_checker.sv]
// scplk_checker: port-level assertions of the step cycle phase lookup, bound to the top
// depends on scplk_pkg and step_cycle_phase_lookup_top
`timescale 1ns / 1ps

module scplk_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_ready,
    input logic                          in_action,
    input logic                          out_valid,
    input logic                          out_ready,
    input logic [scplk_pkg::PHASE_W-1:0] out_phase,
    input logic                          out_uncalibrated
);
    import scplk_pkg::*;

    // an uncalibrated result always carries phase zero
    a_uncal_phase: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_uncalibrated |-> out_phase == '0)
        else $error("uncalibrated result with nonzero phase");

    // a write request answers on the next cycle with a zero result
    a_write_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (in_action == ACTION_WRITE)
        |=> out_valid && (out_phase == '0) && !out_uncalibrated)
        else $error("write request result missing or not zero");

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready
        |=> out_valid && $stable(out_phase) && $stable(out_uncalibrated))
        else $error("stalled result changed");

endmodule

bind step_cycle_phase_lookup_top scplk_checker u_scplk_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_ch.valid),
    .in_ready         (in_ch.ready),
    .in_action        (in_ch.action),
    .out_valid        (out_ch.valid),
    .out_ready        (out_ch.ready),
    .out_phase        (out_ch.phase),
    .out_uncalibrated (out_ch.uncalibrated)
);
